// File: rtl/rhc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the read haplotype classifier.
// No dependencies.
package rhc_pkg;

   localparam int DEFAULT_MAX_FLANK = 32;
   localparam int DEFAULT_RUN_BITS  = 16;

   localparam int CNT_BITS   = 16;
   localparam int FLANK_BITS = 6;
   localparam int MDIFF_BITS = 10;
   localparam int CSR_DATA_BITS  = 10;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [FLANK_BITS-1:0] FLANK_RESET = 6'd3;
   localparam logic [MDIFF_BITS-1:0] MDIFF_RESET = 10'd0;
   localparam logic [CNT_BITS-1:0]   CNT_MAX     = {CNT_BITS{1'b1}};

   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 56;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_FLANK_RUN  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_DIFFERENCE = 1'd1;

   typedef enum logic [1:0] {
      HAP_FIRST  = 2'd0,
      HAP_SECOND = 2'd1,
      HAP_NONE   = 2'd2
   } hap_type;

endpackage

// File: rtl/read_haplotype_classifier.sv
`timescale 1ns / 1ps
// Read haplotype classifier: flank-qualified SNV voting over aligned read columns.
// Depends on rhc_pkg.
//
// Channel  Dir  Ports                                 Beat
// req      in   req_tvalid/tready/tdata/tlast         one alignment column, tlast = last column
// rsp      out  rsp_tvalid/tready/tdata               one call per read
// csr      in   csr_wen/csr_index/csr_wdata           one register write
//
// One column per cycle while req_tready is high; the pending-vote FIFO memory is read into a
// register in the cycle before use, with write-to-read forwarding, and pops at most one entry
// per column. A result enters the output register, or the skid register if that is full. A
// two-deep output buffer lets columns keep flowing while one result waits; req_tready drops
// only when both are held. Reset is synchronous; the FIFO memory needs no clearing pass.
module read_haplotype_classifier #(
   parameter int MAX_FLANK = rhc_pkg::DEFAULT_MAX_FLANK,
   parameter int RUN_BITS  = rhc_pkg::DEFAULT_RUN_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] ref_gap, [1] read_gap, [9:2] read_base, [10] snv_present,
   // [18:11] snv_alt_base, [26:19] snv_ref_base, [27] alt_on_first
   input  logic [rhc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] haplotype_call, [17:2] first_votes, [33:18] second_votes,
   // [49:34] neither_votes
   output logic [rhc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                                csr_wen,
   input  logic [rhc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rhc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CB         = rhc_pkg::CNT_BITS;
   localparam int FB         = rhc_pkg::FLANK_BITS;
   localparam int PTR_BITS   = (MAX_FLANK > 1) ? $clog2(MAX_FLANK) : 1;
   localparam int FILL_BITS  = $clog2(MAX_FLANK + 1);
   localparam int STAMP_BITS = $clog2(MAX_FLANK + 128) + 1;
   localparam int ENTRY_BITS = STAMP_BITS + 2;
   localparam int FLANK_CAP  = (MAX_FLANK < 63) ? MAX_FLANK : 63;

   // configuration
   logic [FB-1:0]                  min_flank_ff;
   logic [rhc_pkg::MDIFF_BITS-1:0] min_diff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_flank_ff <= rhc_pkg::FLANK_RESET;
         min_diff_ff  <= rhc_pkg::MDIFF_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            rhc_pkg::CSR_MIN_FLANK_RUN:  min_flank_ff <= csr_wdata[FB-1:0];
            rhc_pkg::CSR_MIN_DIFFERENCE: min_diff_ff  <= csr_wdata[rhc_pkg::MDIFF_BITS-1:0];
            default: ;
         endcase
      end
   end

   // per-read state
   logic [RUN_BITS-1:0]   run_ff, run_in;
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;
   logic [PTR_BITS-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic [CB-1:0]         first_ff, first_in, second_ff, second_in, neither_ff, neither_in;

   // FIFO memory: {vote, deadline stamp}
   logic [ENTRY_BITS-1:0] fifo_mem [MAX_FLANK];
   logic [ENTRY_BITS-1:0] head_rd_ff;
   logic                  mem_we;
   logic [ENTRY_BITS-1:0] mem_wdata;

   // output buffer
   logic                           out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic [rhc_pkg::RSP_DATA_BITS-1:0] out_data_ff, out_data_in, skid_data_ff, skid_data_in;

   logic                         accept, gapless, clear, pop, push_req, push_ok, imm_vote;
   logic [FB-1:0]                flank;
   logic [STAMP_BITS-1:0]        stamp_cur, stamp_diff;
   logic [FILL_BITS-1:0]         fill_after_pop;
   rhc_pkg::hap_type             new_vote, head_vote, call;
   logic [1:0]                   inc_first, inc_second, inc_neither;
   logic [rhc_pkg::RSP_DATA_BITS-1:0] result;

   logic       ref_gap, read_gap, snv_present, alt_on_first;
   logic [7:0] read_base, alt_base, ref_base;

   assign ref_gap      = req_tdata[0];
   assign read_gap     = req_tdata[1];
   assign read_base    = req_tdata[9:2];
   assign snv_present  = req_tdata[10];
   assign alt_base     = req_tdata[18:11];
   assign ref_base     = req_tdata[26:19];
   assign alt_on_first = req_tdata[27];

   function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
      ptr_inc = (p == PTR_BITS'(MAX_FLANK - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] c, input logic [1:0] d);
      logic [CB:0] s;
      s = {1'b0, c} + (CB + 1)'(d);
      sat_add = s[CB] ? rhc_pkg::CNT_MAX : s[CB-1:0];
   endfunction

   always_comb begin
      accept    = req_tvalid && req_tready;
      gapless   = !ref_gap && !read_gap;
      clear     = accept && req_tlast;
      flank     = (min_flank_ff > FB'(FLANK_CAP)) ? FB'(FLANK_CAP) : min_flank_ff;
      stamp_cur = stamp_ff + 1'b1;
      head_vote = rhc_pkg::hap_type'(head_rd_ff[ENTRY_BITS-1 -: 2]);
      stamp_diff = head_rd_ff[STAMP_BITS-1:0] - stamp_cur;

      pop = accept && gapless && (fill_ff != '0)
            && (stamp_diff[STAMP_BITS-1] || (stamp_diff == '0));
      fill_after_pop = fill_ff - FILL_BITS'(pop);

      if (read_base == alt_base)
         new_vote = alt_on_first ? rhc_pkg::HAP_FIRST : rhc_pkg::HAP_SECOND;
      else if (read_base == ref_base)
         new_vote = alt_on_first ? rhc_pkg::HAP_SECOND : rhc_pkg::HAP_FIRST;
      else
         new_vote = rhc_pkg::HAP_NONE;

      push_req = accept && gapless && snv_present && (run_ff >= RUN_BITS'(flank));
      imm_vote = push_req && (flank == '0);
      push_ok  = push_req && (flank != '0) && (fill_after_pop < FILL_BITS'(MAX_FLANK));

      mem_we    = push_ok && !req_tlast;
      mem_wdata = {new_vote, stamp_cur + STAMP_BITS'(flank)};

      inc_first   = {1'b0, pop && head_vote == rhc_pkg::HAP_FIRST}
                  + {1'b0, imm_vote && new_vote == rhc_pkg::HAP_FIRST};
      inc_second  = {1'b0, pop && head_vote == rhc_pkg::HAP_SECOND}
                  + {1'b0, imm_vote && new_vote == rhc_pkg::HAP_SECOND};
      inc_neither = {1'b0, pop && head_vote == rhc_pkg::HAP_NONE}
                  + {1'b0, imm_vote && new_vote == rhc_pkg::HAP_NONE};

      first_in   = sat_add(first_ff, inc_first);
      second_in  = sat_add(second_ff, inc_second);
      neither_in = sat_add(neither_ff, inc_neither);

      if ({1'b0, first_in} > {1'b0, second_in} + (CB + 1)'(min_diff_ff)
          && first_in > neither_in)
         call = rhc_pkg::HAP_FIRST;
      else if ({1'b0, second_in} > {1'b0, first_in} + (CB + 1)'(min_diff_ff)
               && second_in > neither_in)
         call = rhc_pkg::HAP_SECOND;
      else
         call = rhc_pkg::HAP_NONE;
      result = {6'd0, neither_in, second_in, first_in, call};

      run_in   = run_ff;
      stamp_in = stamp_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      fill_in  = fill_ff;
      if (accept) begin
         if (!gapless) begin
            run_in  = '0;
            head_in = '0;
            tail_in = '0;
            fill_in = '0;
         end else begin
            run_in   = (run_ff == '1) ? run_ff : run_ff + 1'b1;
            stamp_in = stamp_cur;
            head_in  = pop ? ptr_inc(head_ff) : head_ff;
            tail_in  = push_ok ? ptr_inc(tail_ff) : tail_ff;
            fill_in  = fill_after_pop + FILL_BITS'(push_ok);
         end
      end
      if (clear) begin
         run_in     = '0;
         stamp_in   = '0;
         head_in    = '0;
         tail_in    = '0;
         fill_in    = '0;
         first_in   = '0;
         second_in  = '0;
         neither_in = '0;
      end else if (!accept) begin
         first_in   = first_ff;
         second_in  = second_ff;
         neither_in = neither_ff;
      end

      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in  = skid_valid_ff || clear;
         out_data_in   = skid_valid_ff ? skid_data_ff : result;
         skid_valid_in = 1'b0;
      end else if (clear) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end
   end

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff        <= '0;
         stamp_ff      <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         first_ff      <= '0;
         second_ff     <= '0;
         neither_ff    <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         run_ff        <= run_in;
         stamp_ff      <= stamp_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
         neither_ff    <= neither_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // head entry is registered from the next head pointer; a write to the next head forwards
   always_ff @(posedge clock) begin
      if (mem_we)
         fifo_mem[tail_ff] <= mem_wdata;
      if (mem_we && (tail_ff == head_in))
         head_rd_ff <= mem_wdata;
      else
         head_rd_ff <= fifo_mem[head_in];
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for read_haplotype_classifier. It streams aligned read columns,
// predicts each read's haplotype call and vote counts, and checks every result beat.
// Depends on rhc_pkg and the classifier RTL.
module tb_top;

   localparam int MAX_FLANK   = rhc_pkg::DEFAULT_MAX_FLANK;
   localparam int RUN_BITS    = rhc_pkg::DEFAULT_RUN_BITS;
   localparam int QUIET_LIMIT = 1000;
   localparam int PRINT_LIMIT = 40;

   typedef struct {
      logic       ref_gap;
      logic       read_gap;
      logic [7:0] read_base;
      logic       snv_present;
      logic [7:0] alt_base;
      logic [7:0] ref_base;
      logic       alt_on_first;
      logic       last_column;
   } column_type;

   typedef struct {
      rhc_pkg::hap_type             call;
      logic [rhc_pkg::CNT_BITS-1:0] first_votes, second_votes, neither_votes;
   } read_call_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [rhc_pkg::REQ_DATA_BITS-1:0]  req_tdata;
   logic                               req_tlast;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [rhc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                               csr_wen;
   logic [rhc_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [rhc_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   // predicted classifier state
   logic [rhc_pkg::FLANK_BITS-1:0] flank_reg;
   logic [rhc_pkg::MDIFF_BITS-1:0] mdiff_reg;
   logic [RUN_BITS-1:0]            gapless_run;
   int                             vote_wait [MAX_FLANK];
   rhc_pkg::hap_type               vote_kind [MAX_FLANK];
   int                             votes_waiting;
   logic [rhc_pkg::CNT_BITS-1:0]   first_tally, second_tally, neither_tally;
   read_call_type                  calls_due [$];

   int errors = 0;
   int quiet_cycles = 0;
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;

   read_haplotype_classifier u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void clear_tallies();
      gapless_run   = '0;
      votes_waiting = 0;
      first_tally   = '0;
      second_tally  = '0;
      neither_tally = '0;
   endfunction

   function automatic void tally(input rhc_pkg::hap_type v);
      case (v)
         rhc_pkg::HAP_FIRST:  if (first_tally != rhc_pkg::CNT_MAX) first_tally++;
         rhc_pkg::HAP_SECOND: if (second_tally != rhc_pkg::CNT_MAX) second_tally++;
         default:             if (neither_tally != rhc_pkg::CNT_MAX) neither_tally++;
      endcase
   endfunction

   function automatic void classify_column(input column_type c);
      int               flank, k, h0, h1, h2, md;
      rhc_pkg::hap_type v;
      read_call_type    r;
      flank = (flank_reg < MAX_FLANK) ? int'(flank_reg) : MAX_FLANK;
      if (c.ref_gap || c.read_gap) begin
         gapless_run   = '0;
         votes_waiting = 0;
      end else begin
         for (k = 0; k < votes_waiting; k++)
            if (vote_wait[k] > 0) vote_wait[k]--;
         if (votes_waiting > 0 && vote_wait[0] == 0) begin
            tally(vote_kind[0]);
            for (k = 1; k < votes_waiting; k++) begin
               vote_wait[k-1] = vote_wait[k];
               vote_kind[k-1] = vote_kind[k];
            end
            votes_waiting--;
         end
         if (c.snv_present && gapless_run >= flank) begin
            if (c.read_base == c.alt_base)
               v = c.alt_on_first ? rhc_pkg::HAP_FIRST : rhc_pkg::HAP_SECOND;
            else if (c.read_base == c.ref_base)
               v = c.alt_on_first ? rhc_pkg::HAP_SECOND : rhc_pkg::HAP_FIRST;
            else
               v = rhc_pkg::HAP_NONE;
            if (flank == 0) begin
               tally(v);
            end else if (votes_waiting < MAX_FLANK) begin
               vote_wait[votes_waiting] = flank;
               vote_kind[votes_waiting] = v;
               votes_waiting++;
            end
         end
         if (gapless_run != {RUN_BITS{1'b1}}) gapless_run++;
      end
      if (c.last_column) begin
         h0 = first_tally;
         h1 = second_tally;
         h2 = neither_tally;
         md = mdiff_reg;
         if (h0 - md > h1 && h0 > h2) r.call = rhc_pkg::HAP_FIRST;
         else if (h1 - md > h0 && h1 > h2) r.call = rhc_pkg::HAP_SECOND;
         else r.call = rhc_pkg::HAP_NONE;
         r.first_votes   = first_tally;
         r.second_votes  = second_tally;
         r.neither_votes = neither_tally;
         calls_due = {calls_due, r};
         clear_tallies();
      end
   endfunction

   task automatic report(input string msg);
      if (errors < PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
      errors++;
   endtask

   always @(posedge clock) begin : monitor
      column_type    beat_col;
      read_call_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (calls_due.size() == 0) begin
            report($sformatf("result beat with no read pending, tdata %h", rsp_tdata));
         end else begin
            due = calls_due.pop_front();
            if (rsp_tdata[1:0] !== due.call)
               report($sformatf("call got %0d want %0d", rsp_tdata[1:0], due.call));
            if (rsp_tdata[17:2] !== due.first_votes)
               report($sformatf("first votes got %0d want %0d", rsp_tdata[17:2],
                                due.first_votes));
            if (rsp_tdata[33:18] !== due.second_votes)
               report($sformatf("second votes got %0d want %0d", rsp_tdata[33:18],
                                due.second_votes));
            if (rsp_tdata[49:34] !== due.neither_votes)
               report($sformatf("neither votes got %0d want %0d", rsp_tdata[49:34],
                                due.neither_votes));
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         beat_col.ref_gap      = req_tdata[0];
         beat_col.read_gap     = req_tdata[1];
         beat_col.read_base    = req_tdata[9:2];
         beat_col.snv_present  = req_tdata[10];
         beat_col.alt_base     = req_tdata[18:11];
         beat_col.ref_base     = req_tdata[26:19];
         beat_col.alt_on_first = req_tdata[27];
         beat_col.last_column  = req_tlast;
         classify_column(beat_col);
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wen || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result sink: random stall before each beat, with stall-free stretches
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
         stall = rx_steady ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic column_type col(input logic rg, input logic dg, input logic [7:0] base,
                                      input logic snv, input logic [7:0] alt,
                                      input logic [7:0] refb, input logic aof,
                                      input logic last);
      col.ref_gap      = rg;
      col.read_gap     = dg;
      col.read_base    = base;
      col.snv_present  = snv;
      col.alt_base     = alt;
      col.ref_base     = refb;
      col.alt_on_first = aof;
      col.last_column  = last;
   endfunction

   function automatic logic [7:0] base_letter();
      case ($urandom_range(0, 4))
         0:       base_letter = "A";
         1:       base_letter = "C";
         2:       base_letter = "G";
         3:       base_letter = "T";
         default: base_letter = 8'($urandom);
      endcase
   endfunction

   // valid stays high when no gap is drawn, so the next call simply reloads the beat
   task automatic send_column(input column_type c);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, c.alt_on_first, c.ref_base, c.alt_base, c.snv_present,
                     c.read_base, c.read_gap, c.ref_gap};
      req_tlast  <= c.last_column;
      do @(posedge clock); while (!req_tready);
      gap = tx_steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_calls();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (calls_due.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rhc_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [rhc_pkg::CSR_DATA_BITS-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == rhc_pkg::CSR_MIN_FLANK_RUN) flank_reg = val[rhc_pkg::FLANK_BITS-1:0];
      else mdiff_reg = val;
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [rhc_pkg::FLANK_BITS-1:0] flank,
                             input logic [rhc_pkg::MDIFF_BITS-1:0] md);
      logic [rhc_pkg::CSR_DATA_BITS-rhc_pkg::FLANK_BITS-1:0] junk;
      junk = ($urandom_range(0, 1) == 0) ? '0
           : (rhc_pkg::CSR_DATA_BITS - rhc_pkg::FLANK_BITS)'($urandom);
      drain_calls();
      write_reg(rhc_pkg::CSR_MIN_FLANK_RUN, {junk, flank});
      write_reg(rhc_pkg::CSR_MIN_DIFFERENCE, md);
   endtask

   task automatic send_read(input int len, input int gap_odds, input bit lean_second,
                            input bit dense);
      column_type c;
      int         i, pick;
      for (i = 0; i < len; i++) begin
         c.ref_gap  = 1'b0;
         c.read_gap = 1'b0;
         if ($urandom_range(0, gap_odds) == 0) begin
            pick       = $urandom_range(1, 3);
            c.ref_gap  = pick[0];
            c.read_gap = pick[1];
         end
         c.snv_present  = dense || ($urandom_range(0, 2) == 0);
         c.alt_base     = base_letter();
         c.ref_base     = base_letter();
         c.alt_on_first = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 19);
         if (pick < 14)
            c.read_base = (lean_second ^ c.alt_on_first) ? c.alt_base : c.ref_base;
         else if (pick < 17)
            c.read_base = (lean_second ^ c.alt_on_first) ? c.ref_base : c.alt_base;
         else
            c.read_base = base_letter();
         c.last_column = (i == len - 1);
         send_column(c);
      end
   endtask

   task automatic test_directed_columns();
      set_config(1, 0);
      send_column(col(0, 0, "A", 0, 0, 0, 0, 0));
      send_column(col(0, 0, "A", 1, "A", "C", 1, 0));
      send_column(col(0, 0, "C", 1, "A", "C", 0, 0));
      send_column(col(0, 0, "G", 1, "A", "C", 1, 0));
      send_column(col(0, 0, "T", 1, "T", "T", 0, 0));   // alt equal to ref
      send_column(col(1, 0, "T", 1, "T", "T", 0, 0));   // gap drops the waiting vote
      send_column(col(0, 0, "A", 0, 0, 0, 0, 1));
      send_column(col(0, 1, 8'hFF, 1, 8'hFF, 8'hFF, 1, 0));
      send_column(col(1, 1, 8'hFF, 1, 8'hFF, 8'hFF, 1, 0));
      send_column(col(0, 0, 8'h00, 1, 8'h00, 8'hFF, 0, 0)); // no leading flank yet
      send_column(col(0, 0, 8'hFF, 1, 8'h00, 8'hFF, 1, 0));
      send_column(col(0, 0, 8'h00, 1, 8'h00, 8'hFF, 1, 1)); // waiting vote lost at read end
      send_column(col(0, 0, 8'h00, 0, 8'h00, 8'h00, 0, 1)); // single-column read
      set_config(0, 10'h3FF);
      send_column(col(0, 0, "A", 1, "A", "G", 1, 0));
      send_column(col(0, 0, "A", 1, "A", "G", 1, 0));
      send_column(col(1, 1, "A", 1, "A", "G", 1, 1));
      set_config(0, 0);
      send_column(col(0, 0, "G", 1, "A", "G", 1, 0));
      send_column(col(0, 0, "A", 1, "A", "G", 1, 1));   // tie
      send_column(col(0, 0, "C", 1, "C", "G", 1, 0));
      send_column(col(0, 0, "T", 1, "C", "G", 1, 0));
      send_column(col(0, 0, "T", 1, "C", "G", 0, 1));   // neither outvotes first
      set_config(6'h3F, 0);                             // flank clipped to the maximum
      send_column(col(0, 0, "A", 1, "A", "C", 1, 1));
   endtask

   task automatic test_random_reads();
      int                             phase, reads, columns, flank, eff, len;
      logic [rhc_pkg::MDIFF_BITS-1:0] md;
      phase   = 0;
      reads   = 0;
      columns = 0;
      while (columns < 500 || reads < 48) begin
         if (reads % 6 == 0) begin
            case (phase)
               0: begin flank = 0;  md = 0;      end
               1: begin flank = 63; md = 10'h3FF; end
               2: begin flank = 1;  md = 1;      end
               3: begin flank = 32; md = 0;      end
               default: begin
                  flank = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, 6);
                  md    = (rhc_pkg::MDIFF_BITS)'(($urandom_range(0, 4) == 0)
                                                 ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, 3));
               end
            endcase
            set_config((rhc_pkg::FLANK_BITS)'(flank), md);
            phase++;
         end
         eff = (flank < MAX_FLANK) ? flank : MAX_FLANK;
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4)
                                           : $urandom_range(1, 2 * eff + 12);
         tx_steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0) drain_calls();
         send_read(len, ($urandom_range(0, 3) == 0) ? 3 : 24, 1'($urandom_range(0, 1)),
                   $urandom_range(0, 3) == 0);
         columns += len;
         reads++;
      end
      tx_steady = 1'b0;
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_wen    <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      flank_reg = rhc_pkg::FLANK_RESET;
      mdiff_reg = rhc_pkg::MDIFF_RESET;
      clear_tallies();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_columns();
      test_random_reads();

      req_tvalid <= 1'b0;
      do @(posedge clock); while (calls_due.size() != 0);
      repeat (8) @(posedge clock);
      if (errors == 0 && calls_due.size() == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: filelist.f
rtl/rhc_pkg.sv
rtl/read_haplotype_classifier.sv
bench/tb_top.sv
